// ===== rtl/lbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// lbfl_pkg
// Types and constants shared by the LIFO free-list buffer pool.
// ----------------------------------------------------------------------------
package lbfl_pkg;

   // Field widths fixed by the request and response formats.
   localparam int INDEX_WIDTH  = 8;
   localparam int COUNT_WIDTH  = 9;
   localparam int SIZE_WIDTH   = 16;
   localparam int OFFSET_WIDTH = 24;
   localparam int CSR_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   // Largest pool the 9-bit count register can ask for.
   localparam int COUNT_LIMIT = 511;
   // Reset values of the configuration registers.
   localparam int COUNT_DEFAULT = 256;
   localparam logic [SIZE_WIDTH-1:0] SIZE_DEFAULT = 16'd2048;

   // Request opcodes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POOL_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUFFER_SIZE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                   opcode;
      logic [INDEX_WIDTH-1:0] put_index;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [INDEX_WIDTH-1:0]  buffer_index;
      logic [OFFSET_WIDTH-1:0] buffer_offset;
      logic [COUNT_WIDTH-1:0]  free_count;
   } rsp_type;

   // Operation handed to the stack in the processing cycle.
   typedef struct packed {
      logic                   fire;
      logic                   opcode;
      logic [INDEX_WIDTH-1:0] put_index;
   } stack_cmd_type;

   // Reload of the free stack with a new pool size.
   typedef struct packed {
      logic                   load;
      logic [COUNT_WIDTH-1:0] pool_count;
   } stack_init_type;

   typedef struct packed {
      status_type             status;
      logic [INDEX_WIDTH-1:0] buffer_index;
      logic [COUNT_WIDTH-1:0] free_count;
   } stack_res_type;

endpackage

// ===== rtl/lbfl_stack.sv =====
// ----------------------------------------------------------------------------
// lbfl_stack
// Free-index stack: a RAM of pushed indices plus registers caching the two
// topmost entries, so that a pop or push can be served every cycle.
// ----------------------------------------------------------------------------
module lbfl_stack #(
   parameter int STACK_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lbfl_pkg::stack_init_type          init,
   input  logic [lbfl_pkg::COUNT_WIDTH-1:0]  pool_count,
   input  lbfl_pkg::stack_cmd_type           cmd,
   output lbfl_pkg::stack_res_type           res
);

   localparam int AW = $clog2(STACK_DEPTH);

   // Entries below the low-water mark have never been pushed since the last
   // reload and still hold their own index; the RAM needs no clearing.
   logic [lbfl_pkg::INDEX_WIDTH-1:0] stack_mem_ff [STACK_DEPTH];

   logic [lbfl_pkg::COUNT_WIDTH-1:0] top_ff, top_in;
   logic [lbfl_pkg::COUNT_WIDTH-1:0] low_ff, low_in;
   logic [lbfl_pkg::INDEX_WIDTH-1:0] head_ff, head_in;
   logic [lbfl_pkg::INDEX_WIDTH-1:0] second_ff, second_in;
   logic                             second_sel_ff, second_sel_in;
   logic [lbfl_pkg::INDEX_WIDTH-1:0] rd_data_ff;
   logic [lbfl_pkg::COUNT_WIDTH-1:0] rd_addr_ff, rd_addr_in;
   logic                             rd_ok_ff, rd_ok_in;

   logic [lbfl_pkg::INDEX_WIDTH-1:0] second_cur;
   logic                             is_get;
   logic                             is_put;
   logic                             pop;
   logic                             push;
   logic [lbfl_pkg::COUNT_WIDTH-1:0] init_less1;
   logic [lbfl_pkg::COUNT_WIDTH-1:0] init_less2;

   // After a pop the entry below the head comes from the RAM read issued in
   // that cycle; otherwise it sits in second_ff.
   assign second_cur = second_sel_ff ? (rd_ok_ff ? rd_data_ff
                                                 : rd_addr_ff[lbfl_pkg::INDEX_WIDTH-1:0])
                                     : second_ff;

   assign is_get = cmd.fire && (cmd.opcode == lbfl_pkg::OP_GET);
   assign is_put = cmd.fire && (cmd.opcode == lbfl_pkg::OP_PUT);
   assign pop    = is_get && (top_ff != '0);
   assign push   = is_put && (top_ff < pool_count);

   assign init_less1 = init.pool_count - 9'd1;
   assign init_less2 = init.pool_count - 9'd2;

   always_comb begin
      top_in        = top_ff;
      head_in       = head_ff;
      second_in     = second_cur;
      second_sel_in = pop;
      if (pop) begin
         top_in  = top_ff - 9'd1;
         head_in = second_cur;
      end else if (push) begin
         top_in    = top_ff + 9'd1;
         head_in   = cmd.put_index;
         second_in = head_ff;
      end
      low_in = (top_in < low_ff) ? top_in : low_ff;
      // Prefetch the entry that becomes second if this cycle pops.
      rd_addr_in = (top_ff >= 9'd3) ? (top_ff - 9'd3) : '0;
      rd_ok_in   = (rd_addr_in >= low_ff);
   end

   always_comb begin
      res.status       = lbfl_pkg::STATUS_OK;
      res.buffer_index = '0;
      res.free_count   = top_in;
      priority if (is_get && !pop) begin
         res.status = lbfl_pkg::STATUS_EMPTY;
      end else if (is_put && !push) begin
         res.status = lbfl_pkg::STATUS_FULL;
      end else if (pop) begin
         res.buffer_index = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || init.load) begin
         top_ff        <= init.pool_count;
         low_ff        <= init.pool_count;
         head_ff       <= init_less1[lbfl_pkg::INDEX_WIDTH-1:0];
         second_ff     <= init_less2[lbfl_pkg::INDEX_WIDTH-1:0];
         second_sel_ff <= 1'b0;
      end else begin
         top_ff        <= top_in;
         low_ff        <= low_in;
         head_ff       <= head_in;
         second_ff     <= second_in;
         second_sel_ff <= second_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rd_ok_ff   <= rd_ok_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem_ff[top_ff[AW-1:0]] <= cmd.put_index;
      end
      rd_data_ff <= stack_mem_ff[rd_addr_in[AW-1:0]];
   end

   a_top_in_pool: assert property (@(posedge clock) disable iff (reset)
      top_ff <= pool_count)
      else $error("free stack top above pool count");

   a_low_below_top: assert property (@(posedge clock) disable iff (reset)
      low_ff <= top_ff)
      else $error("low-water mark above stack top");

   a_lifo_order: assert property (@(posedge clock) disable iff (reset)
      (push && !init.load) |=> (pop |-> (res.buffer_index == $past(cmd.put_index))))
      else $error("pop after push did not return the pushed index");

endmodule

// ===== rtl/lifo_buffer_free_list_unit.sv =====
// ----------------------------------------------------------------------------
// lifo_buffer_free_list_unit
// Requests and responses are registered. Throughput: one request per cycle while
// rsp_stall is low; the free stack caches its two top entries and prefetches
// the third from its RAM, so back-to-back pops need no wait.
// Reset loads the stack with indices 0 to pool_count-1, as does every write of
// pool_count; the RAM is never cleared and no request is held off after reset.
// ----------------------------------------------------------------------------
module lifo_buffer_free_list_unit #(
   parameter int POOL_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lbfl_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lbfl_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [lbfl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lbfl_pkg::CSR_WIDTH-1:0]       csr_wdata
);

   // The 9-bit pool count cannot reach entries beyond COUNT_LIMIT.
   localparam int STACK_DEPTH = (POOL_DEPTH < lbfl_pkg::COUNT_LIMIT) ? POOL_DEPTH
                                                                    : lbfl_pkg::COUNT_LIMIT;
   localparam logic [lbfl_pkg::COUNT_WIDTH-1:0] COUNT_MAX = 9'(STACK_DEPTH);
   localparam logic [lbfl_pkg::COUNT_WIDTH-1:0] COUNT_RESET =
      9'((STACK_DEPTH < lbfl_pkg::COUNT_DEFAULT) ? STACK_DEPTH : lbfl_pkg::COUNT_DEFAULT);

   logic                                in_valid_ff, in_valid_in;
   lbfl_pkg::req_type                   in_data_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   lbfl_pkg::rsp_type                   rsp_data_ff;
   logic [lbfl_pkg::COUNT_WIDTH-1:0]    pool_count_ff, pool_count_in;
   logic [lbfl_pkg::SIZE_WIDTH-1:0]     buffer_size_ff;

   logic                                req_take;
   logic                                proc_fire;
   logic                                count_write;
   logic [lbfl_pkg::COUNT_WIDTH-1:0]    count_raw;
   logic [lbfl_pkg::OFFSET_WIDTH-1:0]   offset;
   lbfl_pkg::stack_cmd_type             stack_cmd;
   lbfl_pkg::stack_init_type            stack_init;
   lbfl_pkg::stack_res_type             stack_res;

   assign proc_fire = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !proc_fire;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !proc_fire);
   assign rsp_valid_in = proc_fire || (rsp_valid_ff && rsp_stall);

   // A count of zero is taken as one; larger than the stack saturates.
   assign count_write = csr_wr_en && (csr_index == lbfl_pkg::CSR_POOL_COUNT);
   assign count_raw   = csr_wdata[lbfl_pkg::COUNT_WIDTH-1:0];
   always_comb begin
      priority if (count_raw == '0) begin
         pool_count_in = 9'd1;
      end else if (count_raw > COUNT_MAX) begin
         pool_count_in = COUNT_MAX;
      end else begin
         pool_count_in = count_raw;
      end
   end

   assign stack_init.load       = count_write;
   assign stack_init.pool_count = reset ? COUNT_RESET : pool_count_in;

   assign stack_cmd.fire      = proc_fire;
   assign stack_cmd.opcode    = in_data_ff.opcode;
   assign stack_cmd.put_index = in_data_ff.put_index;

   lbfl_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .init       (stack_init),
      .pool_count (pool_count_ff),
      .cmd        (stack_cmd),
      .res        (stack_res)
   );

   // An 8 by 16 product fits the 24-bit offset exactly.
   assign offset = 24'(stack_res.buffer_index) * 24'(buffer_size_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_count_ff  <= COUNT_RESET;
         buffer_size_ff <= lbfl_pkg::SIZE_DEFAULT;
      end else if (csr_wr_en) begin
         if (csr_index == lbfl_pkg::CSR_POOL_COUNT) begin
            pool_count_ff <= pool_count_in;
         end else begin
            buffer_size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (proc_fire) begin
         rsp_data_ff.status        <= stack_res.status;
         rsp_data_ff.buffer_index  <= stack_res.buffer_index;
         rsp_data_ff.buffer_offset <= offset;
         rsp_data_ff.free_count    <= stack_res.free_count;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== test/lifo_buffer_free_list_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lifo_buffer_free_list_unit_tb
// Self-checking bench for the LIFO free-list buffer pool. A shadow copy of the
// free stack predicts status, granted index, byte offset and free count for
// every request. Directed edge cases come first, then phases of random
// get/put bursts under several pool sizes and buffer sizes, with random gaps
// on requests and random stalls on responses, then a back-to-back phase.
// ----------------------------------------------------------------------------
module lifo_buffer_free_list_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 256;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_GAP = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lbfl_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lbfl_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [lbfl_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [lbfl_pkg::CSR_WIDTH-1:0] csr_wdata = '0;

   int req_idle_pct = 38;
   int rsp_idle_pct = 38;
   int error_count = 0;
   int cycle_count = 0;

   // Shadow copy of the pool state and its configuration.
   logic [lbfl_pkg::INDEX_WIDTH-1:0] shadow_stack [DEPTH];
   logic [lbfl_pkg::COUNT_WIDTH-1:0] shadow_top;
   logic [lbfl_pkg::COUNT_WIDTH-1:0] shadow_pool_count;
   logic [lbfl_pkg::SIZE_WIDTH-1:0]  shadow_buffer_size;
   lbfl_pkg::rsp_type expected_rsps[$];
   // Buffers handed out and not yet returned, used for well-formed puts.
   logic [lbfl_pkg::INDEX_WIDTH-1:0] granted_bufs[$];

   lifo_buffer_free_list_unit #(
      .POOL_DEPTH(DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lifo_buffer_free_list_unit regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   function automatic logic [lbfl_pkg::COUNT_WIDTH-1:0] clamp_pool_count(
      logic [lbfl_pkg::COUNT_WIDTH-1:0] value);
      if (value == '0) return lbfl_pkg::COUNT_WIDTH'(1);
      if (value > DEPTH) return lbfl_pkg::COUNT_WIDTH'(DEPTH);
      return value;
   endfunction

   function automatic void reload_free_stack();
      for (int i = 0; i < DEPTH; i++) begin
         shadow_stack[i] = lbfl_pkg::INDEX_WIDTH'(i);
      end
      shadow_top = shadow_pool_count;
      granted_bufs.delete();
   endfunction

   function automatic lbfl_pkg::rsp_type predict_pool_response(lbfl_pkg::req_type r);
      lbfl_pkg::rsp_type res;
      res = '0;
      res.status = lbfl_pkg::STATUS_OK;
      if (r.opcode == lbfl_pkg::OP_GET) begin
         if (shadow_top == '0) begin
            res.status = lbfl_pkg::STATUS_EMPTY;
         end else begin
            shadow_top = shadow_top - lbfl_pkg::COUNT_WIDTH'(1);
            res.buffer_index = shadow_stack[shadow_top[lbfl_pkg::INDEX_WIDTH-1:0]];
            res.buffer_offset = lbfl_pkg::OFFSET_WIDTH'(res.buffer_index)
                                * lbfl_pkg::OFFSET_WIDTH'(shadow_buffer_size);
            granted_bufs.push_back(res.buffer_index);
         end
      end else begin
         if (shadow_top >= shadow_pool_count) begin
            res.status = lbfl_pkg::STATUS_FULL;
         end else begin
            shadow_stack[shadow_top[lbfl_pkg::INDEX_WIDTH-1:0]] = r.put_index;
            shadow_top = shadow_top + lbfl_pkg::COUNT_WIDTH'(1);
         end
      end
      res.free_count = shadow_top;
      return res;
   endfunction

   always @(posedge clock) begin : check_rsp
      lbfl_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.buffer_index !== want.buffer_index) begin
               $error("buffer_index: expected %0d, actual %0d",
                      want.buffer_index, rsp_data.buffer_index);
               error_count++;
            end
            if (rsp_data.buffer_offset !== want.buffer_offset) begin
               $error("buffer_offset: expected %0d, actual %0d",
                      want.buffer_offset, rsp_data.buffer_offset);
               error_count++;
            end
            if (rsp_data.free_count !== want.free_count) begin
               $error("free_count: expected %0d, actual %0d",
                      want.free_count, rsp_data.free_count);
               error_count++;
            end
         end
      end
   end

   // Valid is only lowered when a gap follows, so it never drops and rises
   // again within one step.
   task automatic send_request(logic opcode, logic [lbfl_pkg::INDEX_WIDTH-1:0] index);
      int gap;
      lbfl_pkg::req_type r;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct && gap < MAX_GAP) gap++;
      r.opcode = opcode;
      r.put_index = index;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(predict_pool_response(r));
   endtask

   task automatic drain_pool();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [lbfl_pkg::CSR_INDEX_WIDTH-1:0] index,
                            logic [lbfl_pkg::CSR_WIDTH-1:0] value);
      drain_pool();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == lbfl_pkg::CSR_POOL_COUNT) begin
         shadow_pool_count = clamp_pool_count(value[lbfl_pkg::COUNT_WIDTH-1:0]);
         reload_free_stack();
      end else begin
         shadow_buffer_size = value;
      end
   endtask

   task automatic test_edge_cases();
      // Full pool after reset: a put is dropped, then pops and pushes at the top.
      send_request(lbfl_pkg::OP_PUT, 8'hAA);
      send_request(lbfl_pkg::OP_GET, 8'hFF);
      send_request(lbfl_pkg::OP_PUT, 8'h00);
      send_request(lbfl_pkg::OP_GET, 8'h55);
      send_request(lbfl_pkg::OP_PUT, 8'hFF);
      send_request(lbfl_pkg::OP_GET, 8'h00);
      // A count of zero is taken as one; the largest size gives the largest offset.
      write_csr(lbfl_pkg::CSR_POOL_COUNT, 16'd0);
      write_csr(lbfl_pkg::CSR_BUFFER_SIZE, 16'hFFFF);
      send_request(lbfl_pkg::OP_GET, 8'h00);
      send_request(lbfl_pkg::OP_GET, 8'h00);
      send_request(lbfl_pkg::OP_PUT, 8'hFF);
      send_request(lbfl_pkg::OP_PUT, 8'h03);
      send_request(lbfl_pkg::OP_GET, 8'h00);
      send_request(lbfl_pkg::OP_PUT, 8'hFF);
      // A size change leaves the stack alone; a zero size gives zero offsets.
      write_csr(lbfl_pkg::CSR_BUFFER_SIZE, 16'd0);
      send_request(lbfl_pkg::OP_GET, 8'h00);
      // Bits above the count field are ignored.
      write_csr(lbfl_pkg::CSR_POOL_COUNT, 16'hFE02);
      send_request(lbfl_pkg::OP_GET, 8'h00);
      send_request(lbfl_pkg::OP_GET, 8'h00);
      send_request(lbfl_pkg::OP_GET, 8'h00);
      send_request(lbfl_pkg::OP_PUT, 8'h80);
      send_request(lbfl_pkg::OP_PUT, 8'h7F);
      send_request(lbfl_pkg::OP_PUT, 8'h01);
      // Counts above the pool depth saturate.
      write_csr(lbfl_pkg::CSR_POOL_COUNT, 16'd300);
      send_request(lbfl_pkg::OP_PUT, 8'h10);
      write_csr(lbfl_pkg::CSR_POOL_COUNT, 16'd511);
      write_csr(lbfl_pkg::CSR_BUFFER_SIZE, 16'd1);
      send_request(lbfl_pkg::OP_GET, 8'h00);
      send_request(lbfl_pkg::OP_GET, 8'h00);
   endtask

   // Bursts of mostly gets or mostly puts walk the stack between empty and
   // full; most puts return a buffer that was granted earlier.
   task automatic run_pool_phase(logic [lbfl_pkg::COUNT_WIDTH-1:0] count_setting,
                                 logic [lbfl_pkg::SIZE_WIDTH-1:0] size_setting,
                                 int num_requests);
      int remaining;
      int burst;
      int pick;
      logic dir;
      logic op;
      logic [lbfl_pkg::INDEX_WIDTH-1:0] index;
      logic [lbfl_pkg::CSR_WIDTH-1:0] count_word;
      count_word = lbfl_pkg::CSR_WIDTH'($urandom);
      count_word[lbfl_pkg::COUNT_WIDTH-1:0] = count_setting;
      write_csr(lbfl_pkg::CSR_POOL_COUNT, count_word);
      write_csr(lbfl_pkg::CSR_BUFFER_SIZE, size_setting);
      remaining = num_requests;
      while (remaining > 0) begin
         burst = $urandom_range(shadow_pool_count + 2, 1);
         dir = 1'($urandom_range(1));
         while (burst > 0 && remaining > 0) begin
            op = ($urandom_range(9) == 0) ? ~dir : dir;
            if (op == lbfl_pkg::OP_PUT && granted_bufs.size() != 0
                && $urandom_range(4) != 0) begin
               pick = $urandom_range(granted_bufs.size() - 1);
               index = granted_bufs[pick];
               granted_bufs.delete(pick);
            end else begin
               index = lbfl_pkg::INDEX_WIDTH'($urandom);
            end
            send_request(op, index);
            burst--;
            remaining--;
            if ($urandom_range(199) == 0) drain_pool();
         end
      end
   endtask

   task automatic test_random_traffic();
      run_pool_phase(9'd1, 16'hFFFF, 100);
      run_pool_phase(9'd2, 16'd1, 100);
      run_pool_phase(9'd7, lbfl_pkg::SIZE_WIDTH'($urandom), 125);
      run_pool_phase(9'd16, 16'd0, 125);
      run_pool_phase(lbfl_pkg::COUNT_WIDTH'($urandom_range(40, 3)),
                     lbfl_pkg::SIZE_WIDTH'($urandom), 150);
      run_pool_phase(9'd256, 16'd2048, 150);
      run_pool_phase(9'd0, lbfl_pkg::SIZE_WIDTH'($urandom), 100);
      run_pool_phase(9'd511, 16'hFFFF, 150);
      run_pool_phase(9'd33, lbfl_pkg::SIZE_WIDTH'($urandom_range(65535, 1)), 125);
   endtask

   task automatic test_back_to_back();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_pool_phase(9'd5, lbfl_pkg::SIZE_WIDTH'($urandom), 120);
      req_idle_pct = 38;
      rsp_idle_pct = 38;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      shadow_pool_count = lbfl_pkg::COUNT_WIDTH'(lbfl_pkg::COUNT_DEFAULT);
      shadow_buffer_size = lbfl_pkg::SIZE_DEFAULT;
      reload_free_stack();
      test_edge_cases();
      test_random_traffic();
      test_back_to_back();
      drain_pool();
      if (error_count == 0) begin
         $display("lifo_buffer_free_list_unit regression: pass");
      end else begin
         $display("lifo_buffer_free_list_unit regression: fail");
      end
      $finish;
   end

endmodule
